// ===== src/tgel_pkg.sv =====
package tgel_pkg;

    localparam int W_DIV = 100;
    localparam int N_DIV = 12;

    localparam logic signed [15:0] TANH_LIMIT = 16'sd10240;
    localparam logic signed [12:0] Q_ONE      = 13'sd2048;

    typedef struct packed {
        logic [16:0] ax;
        logic        negx;
        logic        last;
        logic        sat;
        logic        negu;
    } t_side;

endpackage

// ===== src/tgel_if.sv =====
interface tgel_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample;
    logic        last_in;

    modport source (output valid, output sample, output last_in, input ready);
    modport sink   (input valid, input sample, input last_in, output ready);
endinterface

interface tgel_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] activation;
    logic        last_out;

    modport source (output valid, output activation, output last_out, input ready);
    modport sink   (input valid, input activation, input last_out, output ready);
endinterface

// ===== src/tanh_gelu_activation_top.sv =====
// Tanh / tanh-approximated GELU activation on signed Q4.11 samples.
//
// Requests enter on i_in (sample, last_in) and results leave on o_out
// (activation, last_out) with valid/ready handshakes. A request is taken at
// every clock edge where valid and ready are both high.
// The configuration bit i_cfg_wdata is written when i_cfg_we is high; 0 selects
// tanh, 1 selects GELU. Change it only while no request is in flight.
//
// The datapath is a 23-stage pipeline: nine stages form the GELU argument and
// the Pade numerator and denominator, twelve identical divider cells each
// resolve one quotient bit, then one stage applies sign and saturation and the
// output register holds the final result. One request is taken in every cycle
// while the receiver does not stall the output.
//
// When the receiver holds ready low while a result is waiting, the whole
// pipeline freezes and i_in.ready drops; nothing is lost or duplicated.
// Synchronous active-low reset clears all valid flags and sets the mode to tanh.
module tanh_gelu_activation_top (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cfg_we,
    input  logic  i_cfg_wdata,
    tgel_in_if.sink    i_in,
    tgel_out_if.source o_out
);
    import tgel_pkg::*;

    logic             r_mode;
    logic             w_en;

    logic             w_v   [0:N_DIV];
    logic [W_DIV-1:0] w_rem [0:N_DIV];
    logic [W_DIV-1:0] w_bs  [0:N_DIV];
    logic [N_DIV-1:0] w_q   [0:N_DIV];
    t_side            w_side[0:N_DIV];

    logic               r_tv;
    logic signed [12:0] r_t;
    t_side              r_tside;
    logic               r_ov;
    logic [15:0]        r_oy;
    logic               r_olast;

    logic signed [12:0] n_t;
    logic [12:0]        n_onept;
    logic [29:0]        n_p;
    logic [17:0]        n_mag;
    logic [15:0]        n_y;

    assign w_en      = !r_ov || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    tgel_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_mode   (r_mode),
        .i_valid  (i_in.valid),
        .i_sample (i_in.sample),
        .i_last   (i_in.last_in),
        .o_valid  (w_v[0]),
        .o_rem    (w_rem[0]),
        .o_bs     (w_bs[0]),
        .o_side   (w_side[0])
    );

    assign w_q[0] = '0;

    for (genvar g = 0; g < N_DIV; g++) begin : g_div
        tgel_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_v[g]),
            .i_rem   (w_rem[g]),
            .i_bs    (w_bs[g]),
            .i_q     (w_q[g]),
            .i_side  (w_side[g]),
            .o_valid (w_v[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_bs    (w_bs[g+1]),
            .o_q     (w_q[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    always_comb begin
        if (w_side[N_DIV].sat) begin
            n_t = w_side[N_DIV].negu ? -Q_ONE : Q_ONE;
        end else begin
            n_t = w_side[N_DIV].negu ? -$signed({1'b0, w_q[N_DIV]})
                                     : $signed({1'b0, w_q[N_DIV]});
        end
        n_onept = 13'(Q_ONE + r_t);
        n_p     = 30'(r_tside.ax * n_onept);
        n_mag   = 18'((n_p + 30'd2048) >> 12);
        if (r_mode) begin
            n_y = r_tside.negx ? 16'(-n_mag) : n_mag[15:0];
        end else begin
            n_y = 16'(r_t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_tv <= w_v[N_DIV];
            r_ov <= r_tv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t     <= n_t;
            r_tside <= w_side[N_DIV];
            r_oy    <= n_y;
            r_olast <= r_tside.last;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.activation = r_oy;
    assign o_out.last_out   = r_olast;

endmodule

// ===== src/tgel_front.sv =====
module tgel_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_mode,
    input  logic                       i_valid,
    input  logic [15:0]                i_sample,
    input  logic                       i_last,
    output logic                       o_valid,
    output logic [tgel_pkg::W_DIV-1:0] o_rem,
    output logic [tgel_pkg::W_DIV-1:0] o_bs,
    output tgel_pkg::t_side            o_side
);
    import tgel_pkg::*;

    logic [8:0]         r_v;
    logic [15:0]        r0_x;
    logic               r0_last;
    logic [15:0]        r1_x;
    logic [16:0]        r1_ax;
    logic [30:0]        r1_sq;
    logic               r1_last;
    logic [15:0]        r2_x;
    logic [16:0]        r2_ax;
    logic [43:0]        r2_inner;
    logic               r2_last;
    logic signed [15:0] r3_u;
    t_side              r3_side;
    logic [13:0]        r4_au;
    logic [26:0]        r4_s;
    t_side              r4_side;
    logic [13:0]        r5_au;
    logic [26:0]        r5_s;
    logic [63:0]        r5_n;
    logic [63:0]        r5_d;
    t_side              r5_side;
    logic [13:0]        r6_au;
    logic [89:0]        r6_n;
    logic [89:0]        r6_d;
    t_side              r6_side;
    logic [W_DIV-1:0]   r7_n;
    logic [89:0]        r7_d;
    t_side              r7_side;
    logic [W_DIV-1:0]   r8_rem;
    logic [W_DIV-1:0]   r8_bs;
    t_side              r8_side;

    logic [16:0]        n_ax;
    logic [60:0]        n_prod;
    logic [22:0]        n_mag;
    logic [16:0]        n_magc;
    logic signed [15:0] n_u;
    logic               n_sat;
    logic [16:0]        n_auw;
    logic [30:0]        n_n1;
    logic [33:0]        n_d1;
    logic [119:0]       n_nx;

    always_comb begin
        n_ax   = r0_x[15] ? 17'(-{1'b1, r0_x}) : {1'b0, r0_x};
        n_prod = 61'(r2_inner[21:0] * r2_ax) + (61'(r2_inner[43:22] * r2_ax) << 22);
        n_mag  = 23'((n_prod + (61'd1 << 37)) >> 38);
        if (r2_x[15]) begin
            n_magc = (n_mag > 23'd32768) ? 17'd32768 : n_mag[16:0];
        end else begin
            n_magc = (n_mag > 23'd32767) ? 17'd32767 : n_mag[16:0];
        end
        if (i_mode) begin
            n_u = r2_x[15] ? 16'(-n_magc) : n_magc[15:0];
        end else begin
            n_u = r2_x;
        end
        n_sat = (r3_u > TANH_LIMIT) || (r3_u < -TANH_LIMIT);
        n_auw = r3_u[15] ? 17'(-{r3_u[15], r3_u}) : {1'b0, r3_u};
        n_n1  = 31'(r4_s) + (31'd378 << 22);
        n_d1  = 34'(34'd28 * r4_s) + (34'd3150 << 22);
        n_nx  = 120'(r6_n[29:0] * r6_au) + (120'(r6_n[59:30] * r6_au) << 30)
              + (120'(r6_n[89:60] * r6_au) << 60);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[7:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_x    <= i_sample;
            r0_last <= i_last;

            r1_x    <= r0_x;
            r1_ax   <= n_ax;
            r1_sq   <= 31'(n_ax * n_ax);
            r1_last <= r0_last;

            r2_x     <= r1_x;
            r2_ax    <= r1_ax;
            r2_inner <= (44'd52290 << 22) + 44'(44'd2338 * r1_sq);
            r2_last  <= r1_last;

            r3_u    <= n_u;
            r3_side <= '{ax: r2_ax, negx: r2_x[15], last: r2_last, sat: 1'b0, negu: 1'b0};

            // Saturated arguments keep a zero magnitude; their result is fixed later.
            r4_au   <= n_sat ? 14'd0 : n_auw[13:0];
            r4_s    <= n_sat ? 27'd0 : 27'(n_auw[13:0] * n_auw[13:0]);
            r4_side <= '{ax: r3_side.ax, negx: r3_side.negx, last: r3_side.last,
                         sat: n_sat, negu: r3_u[15]};

            r5_au   <= r4_au;
            r5_s    <= r4_s;
            r5_n    <= 64'(n_n1 * r4_s) + (64'd17325 << 44);
            r5_d    <= 64'(n_d1 * r4_s) + (64'd62370 << 44);
            r5_side <= r4_side;

            r6_au   <= r5_au;
            r6_n    <= 90'(r5_n[31:0] * r5_s) + (90'(r5_n[63:32] * r5_s) << 32)
                     + (90'd135135 << 66);
            r6_d    <= 90'(r5_d[31:0] * r5_s) + (90'(r5_d[63:32] * r5_s) << 32)
                     + (90'd135135 << 66);
            r6_side <= r5_side;

            r7_n    <= n_nx[W_DIV-1:0];
            r7_d    <= r6_d;
            r7_side <= r6_side;

            // Rounded quotient is floor((2N + D) / 2D); the divisor starts shifted
            // up by one less than the quotient width.
            r8_rem  <= (r7_n << 1) + W_DIV'(r7_d);
            r8_bs   <= W_DIV'(r7_d) << N_DIV;
            r8_side <= r7_side;
        end
    end

    assign o_valid = r_v[8];
    assign o_rem   = r8_rem;
    assign o_bs    = r8_bs;
    assign o_side  = r8_side;

endmodule

// ===== src/tgel_div_cell.sv =====
module tgel_div_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [tgel_pkg::W_DIV-1:0] i_rem,
    input  logic [tgel_pkg::W_DIV-1:0] i_bs,
    input  logic [tgel_pkg::N_DIV-1:0] i_q,
    input  tgel_pkg::t_side            i_side,
    output logic                       o_valid,
    output logic [tgel_pkg::W_DIV-1:0] o_rem,
    output logic [tgel_pkg::W_DIV-1:0] o_bs,
    output logic [tgel_pkg::N_DIV-1:0] o_q,
    output tgel_pkg::t_side            o_side
);
    import tgel_pkg::*;

    logic             r_v;
    logic [W_DIV-1:0] r_rem;
    logic [W_DIV-1:0] r_bs;
    logic [N_DIV-1:0] r_q;
    t_side            r_side;
    logic             n_ge;

    assign n_ge = (i_rem >= i_bs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_ge ? (i_rem - i_bs) : i_rem;
            r_bs   <= i_bs >> 1;
            r_q    <= {i_q[N_DIV-2:0], n_ge};
            r_side <= i_side;
        end
    end

    assign o_valid = r_v;
    assign o_rem   = r_rem;
    assign o_bs    = r_bs;
    assign o_q     = r_q;
    assign o_side  = r_side;

endmodule
